FILE: design/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants for the set-associative cache LRU simulator.
// ----------------------------------------------------------------------------
package sacl_pkg;

  // Access kinds carried on the input tuser.
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_STORE  = 2'd1;
  localparam logic [1:0] MODE_MODIFY = 2'd2;
  localparam logic [1:0] MODE_IGNORE = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS       = 2'd2;

  // Field widths.
  localparam int ADDR_W     = 64;
  localparam int CNT_W      = 32;
  localparam int CFG_W      = 6;
  localparam int SHIFT_W    = 7;
  localparam int OUT_DATA_W = 104;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_READ,
    ST_CMP,
    ST_DONE
  } state_t;

endpackage

FILE: design/set_assoc_cache_lru_sim_top.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim_top
// Tag-only set-associative cache model with true LRU ranks and saturating
// hit, miss and eviction totals.
// ----------------------------------------------------------------------------
// Each accepted access is handled by one row unit: the set's whole row of
// tags, valid bits and LRU ages is read from the row memory, compared
// across all ways, and written back in one step. The input stays busy
// while an access is handled; a modify runs the row unit twice, and an
// ignored access skips it. The next access may be taken while a finished
// result still waits on the output. A row that was never written reads as
// empty through a per-row flag cleared by reset, so no clearing pass
// follows reset.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim_top
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  // Access stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [ADDR_W-1:0]     s_axis_tdata,   // [63:0] address
  input  logic [1:0]            s_axis_tuser,   // [1:0] mode
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] hit, [1] miss, [2] eviction, [3] second_hit, [35:4] total_hits,
  // [67:36] total_misses, [99:68] total_evictions, [103:100] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int ROWS      = 1 << MAX_SET_BITS;
  localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int SB_W      = (MAX_SET_BITS > 0) ? $clog2(MAX_SET_BITS + 1) : 1;
  localparam int AGE_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

  // Configuration registers.
  logic [2:0] set_bits;
  logic [5:0] block_bits;
  logic [3:0] ways;

  // Sequencer and item registers.
  state_t state, state_next;
  logic [1:0]        mode_q;
  logic [ADDR_W-1:0] address_q;
  logic [SET_W-1:0]  set_q;
  logic [ADDR_W-1:0] tag_q;
  logic              pass;
  logic              res_hit, res_miss, res_evict, res_second;
  logic [CNT_W-1:0]  hit_counter, miss_counter, evict_counter;

  // Control strobes from the sequencer.
  logic accept, dec_en, rd_en, cmp_en, load_out;

  // Row memory and per-row written flags.
  logic [MAX_WAYS-1:0]            mem_valid [ROWS];
  logic [MAX_WAYS-1:0][ADDR_W-1:0] mem_tag  [ROWS];
  logic [MAX_WAYS-1:0][AGE_W-1:0]  mem_age  [ROWS];
  logic [ROWS-1:0]                 row_live;

  logic [MAX_WAYS-1:0]             rd_valid;
  logic [MAX_WAYS-1:0][ADDR_W-1:0] rd_tag;
  logic [MAX_WAYS-1:0][AGE_W-1:0]  rd_age;
  logic                            rd_live;

  // Output register.
  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  // Configuration writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= '0;
      block_bits <= '0;
      ways       <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SET_BITS:   set_bits   <= cfg_data[2:0];
        REG_BLOCK_BITS: block_bits <= cfg_data;
        REG_WAYS:       ways       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Clamped set bit count and way count.
  logic [SB_W-1:0]      sb;
  logic [WAY_CNT_W-1:0] nw;

  always_comb begin
    if (32'(set_bits) > MAX_SET_BITS) begin
      sb = SB_W'(MAX_SET_BITS);
    end else begin
      sb = SB_W'(set_bits);
    end
    if (ways == 4'd0) begin
      nw = WAY_CNT_W'(1);
    end else if (32'(ways) > MAX_WAYS) begin
      nw = WAY_CNT_W'(MAX_WAYS);
    end else begin
      nw = WAY_CNT_W'(ways);
    end
  end

  // Address decode: set index just above the offset, tag above the set.
  logic [SHIFT_W-1:0] shift_total;
  logic [ADDR_W-1:0]  above, set_mask, tag_dec;
  logic [SET_W-1:0]   set_dec;

  always_comb begin
    shift_total = SHIFT_W'(sb) + SHIFT_W'(block_bits);
    above       = address_q >> block_bits;
    set_mask    = ~({ADDR_W{1'b1}} << sb);
    set_dec     = SET_W'(above & set_mask);
    if (shift_total >= SHIFT_W'(ADDR_W)) begin
      tag_dec = '0;
    end else begin
      tag_dec = address_q >> shift_total[5:0];
    end
  end

  // Row view with never-written rows reading as empty.
  logic [MAX_WAYS-1:0]             cur_valid;
  logic [MAX_WAYS-1:0][AGE_W-1:0]  cur_age;

  always_comb begin
    cur_valid = rd_live ? rd_valid : '0;
    cur_age   = rd_live ? rd_age : '0;
  end

  // Row compare: hit search, first empty way, oldest way, then new ranks.
  logic [MAX_WAYS-1:0]             in_use, match;
  logic                            hit_found, empty_found;
  logic [WAY_W-1:0]                hit_way, empty_way, victim, touch_way;
  logic [AGE_W-1:0]                oldest, touch_age;
  logic                            is_fill;
  logic [MAX_WAYS-1:0]             new_valid;
  logic [MAX_WAYS-1:0][ADDR_W-1:0] new_tag;
  logic [MAX_WAYS-1:0][AGE_W-1:0]  new_age;

  always_comb begin
    hit_found   = 1'b0;
    empty_found = 1'b0;
    hit_way     = '0;
    empty_way   = '0;
    victim      = '0;
    oldest      = cur_age[0];
    for (int j = 0; j < MAX_WAYS; j++) begin
      in_use[j] = nw > WAY_CNT_W'(j);
      match[j]  = in_use[j] && cur_valid[j] && (rd_tag[j] == tag_q);
    end
    // Lowest matching and lowest empty way win.
    for (int j = MAX_WAYS - 1; j >= 0; j--) begin
      if (match[j]) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(j);
      end
      if (in_use[j] && !cur_valid[j]) begin
        empty_found = 1'b1;
        empty_way   = WAY_W'(j);
      end
    end
    // Oldest way; the lowest index wins a tie.
    for (int j = 1; j < MAX_WAYS; j++) begin
      if (in_use[j] && cur_age[j] > oldest) begin
        oldest = cur_age[j];
        victim = WAY_W'(j);
      end
    end
    is_fill = !hit_found && empty_found;
    priority if (hit_found) begin
      touch_way = hit_way;
      touch_age = cur_age[hit_way];
    end else if (empty_found) begin
      touch_way = empty_way;
      touch_age = AGE_MAX;
    end else begin
      touch_way = victim;
      touch_age = oldest;
    end
    for (int j = 0; j < MAX_WAYS; j++) begin
      new_valid[j] = cur_valid[j];
      new_tag[j]   = rd_tag[j];
      new_age[j]   = cur_age[j];
      if (in_use[j]) begin
        if (WAY_W'(j) == touch_way) begin
          new_valid[j] = 1'b1;
          new_tag[j]   = tag_q;
          new_age[j]   = '0;
        end else if (cur_valid[j] && cur_age[j] < AGE_MAX &&
                     (is_fill || cur_age[j] < touch_age)) begin
          new_age[j] = cur_age[j] + AGE_W'(1);
        end
      end
    end
  end

  // Row memory: one read and one write port at the current set.
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      mem_valid[set_q] <= new_valid;
      mem_tag[set_q]   <= new_tag;
      mem_age[set_q]   <= new_age;
    end
    if (rd_en) begin
      rd_valid <= mem_valid[set_q];
      rd_tag   <= mem_tag[set_q];
      rd_age   <= mem_age[set_q];
      rd_live  <= row_live[set_q];
    end
  end

  // Per-row written flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_live <= '0;
    end else if (cmp_en) begin
      row_live[set_q] <= 1'b1;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (s_axis_tuser == MODE_IGNORE) ? ST_DONE : ST_DEC;
        end
      end
      ST_DEC:  state_next = ST_READ;
      ST_READ: state_next = ST_CMP;
      ST_CMP: begin
        state_next = (mode_q == MODE_MODIFY && !pass) ? ST_READ : ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    dec_en        = 1'b0;
    rd_en         = 1'b0;
    cmp_en        = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      ST_IDLE: s_axis_tready = !rst;
      ST_DEC:  dec_en = 1'b1;
      ST_READ: rd_en = 1'b1;
      ST_CMP:  cmp_en = 1'b1;
      ST_DONE: load_out = !out_valid || m_axis_tready;
      default: ;
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item registers and running totals.
  always_ff @(posedge clk) begin
    if (rst) begin
      pass          <= 1'b0;
      res_hit       <= 1'b0;
      res_miss      <= 1'b0;
      res_evict     <= 1'b0;
      res_second    <= 1'b0;
      hit_counter   <= '0;
      miss_counter  <= '0;
      evict_counter <= '0;
    end else begin
      if (accept) begin
        mode_q     <= s_axis_tuser;
        address_q  <= s_axis_tdata;
        pass       <= 1'b0;
        res_hit    <= 1'b0;
        res_miss   <= 1'b0;
        res_evict  <= 1'b0;
        res_second <= 1'b0;
      end
      if (dec_en) begin
        set_q <= set_dec;
        tag_q <= tag_dec;
      end
      if (cmp_en) begin
        pass <= 1'b1;
        if (hit_found) begin
          if (hit_counter != '1) begin
            hit_counter <= hit_counter + CNT_W'(1);
          end
        end else if (!pass) begin
          if (miss_counter != '1) begin
            miss_counter <= miss_counter + CNT_W'(1);
          end
          if (!empty_found && evict_counter != '1) begin
            evict_counter <= evict_counter + CNT_W'(1);
          end
        end
        if (!pass) begin
          res_hit   <= hit_found;
          res_miss  <= !hit_found;
          res_evict <= !hit_found && !empty_found;
        end else begin
          res_second <= hit_found;
        end
      end
    end
  end

  // Output register; the counts are final by the time the result loads.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= {4'b0000, evict_counter, miss_counter, hit_counter,
                   res_second, res_evict, res_miss, res_hit};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

FILE: design/sacl_checker.sv
// ----------------------------------------------------------------------------
// sacl_checker
// Port-level checks for the cache simulator, bound to the top level.
// ----------------------------------------------------------------------------
module sacl_checker
  import sacl_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata   // flags [3:0], totals [99:4]
);

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The block is busy in the cycle right after it takes an access.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transfer");

  // Hit and miss exclude each other, and an eviction only comes with a miss.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]) &&
                      !(m_axis_tdata[2] && !m_axis_tdata[1]))
    else $error("inconsistent hit, miss and eviction flags");

  // Any hit or second hit leaves a nonzero hit total.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[0] || m_axis_tdata[3]) |->
      m_axis_tdata[35:4] != 32'd0)
    else $error("hit reported with a zero hit total");

endmodule

bind set_assoc_cache_lru_sim_top sacl_checker u_sacl_checker (.*);

FILE: verif/tb_set_assoc_cache_lru_sim_top.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_lru_sim_top
// Self-checking bench for the tag-only set-associative LRU cache simulator.
// A short table of directed accesses and register writes runs first. It is
// followed by random phases, each under its own cache geometry. Every
// accepted access is run through a local tag/LRU model, and each result
// transfer is compared field by field with the oldest predicted outcome.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_lru_sim_top
  import sacl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_LOG2_CAP    = 6;
  localparam int WAY_CAP         = 8;
  localparam int LINE_TOTAL      = (1 << SET_LOG2_CAP) * WAY_CAP;
  localparam int RANK_CAP        = WAY_CAP - 1;
  localparam int RAND_PHASES     = 10;
  localparam int ITEMS_PER_PHASE = 133;
  localparam int STALL_LIMIT     = 2000;

  // Result fields, from the most significant down to hit in bit 0.
  typedef struct packed {
    logic [CNT_W-1:0] total_evictions;
    logic [CNT_W-1:0] total_misses;
    logic [CNT_W-1:0] total_hits;
    logic             second_hit;
    logic             eviction;
    logic             miss;
    logic             hit;
  } access_result_t;

  typedef enum logic [1:0] {
    LOOK_HIT,
    LOOK_FILL,
    LOOK_EVICT
  } lookup_t;

  // One row of the directed table: a register write or an access.
  typedef struct packed {
    logic           is_reg;
    logic [1:0]     reg_idx;
    logic [CFG_W-1:0] reg_val;
    logic [1:0]     mode;
    logic [ADDR_W-1:0] addr;
    logic           known;
    access_result_t want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [ADDR_W-1:0]     s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Local copy of the tag store and the registers.
  logic              line_ok  [LINE_TOTAL];
  logic [ADDR_W-1:0] line_key [LINE_TOTAL];
  logic [2:0]        line_rank[LINE_TOTAL];
  logic [CNT_W-1:0]  n_hits, n_misses, n_evicts;
  logic [2:0]        reg_sb;
  logic [5:0]        reg_bb;
  logic [3:0]        reg_ways;

  access_result_t outcome_q[$];
  stim_row_t      stim_rows[$];
  logic [ADDR_W-1:0] key_pool[16];

  int   mismatches   = 0;
  int   results_seen = 0;
  int   settings     = 1;
  int   send_pct     = 20;
  int   stall_pct    = 20;
  int   stall_left   = 0;
  int   idle_run     = 0;
  logic no_pause     = 1'b0;

  set_assoc_cache_lru_sim_top #(
    .MAX_SET_BITS (SET_LOG2_CAP),
    .MAX_WAYS     (WAY_CAP)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk = ~clk;

  // Effective geometry after the block's clamping of out-of-range settings.
  function automatic int unsigned eff_sb();
    return (reg_sb > SET_LOG2_CAP) ? SET_LOG2_CAP : reg_sb;
  endfunction

  function automatic int unsigned eff_ways();
    if (reg_ways == 0) return 1;
    return (reg_ways > WAY_CAP) ? WAY_CAP : reg_ways;
  endfunction

  function automatic logic [CNT_W-1:0] saturating_add1(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Make way w the newest; valid ways that were younger than it age by one.
  function automatic void make_newest(int unsigned base, int unsigned nw, int unsigned w,
                                      logic [2:0] old);
    int unsigned j;
    for (j = 0; j < nw; j++) begin
      if (j != w && line_ok[base+j] && line_rank[base+j] < old &&
          line_rank[base+j] < RANK_CAP)
        line_rank[base+j] = line_rank[base+j] + 3'd1;
    end
    line_rank[base+w] = 3'd0;
  endfunction

  // One lookup in the set that the address selects, with the LRU update.
  function automatic lookup_t touch_line(logic [ADDR_W-1:0] addr);
    int unsigned sb, bb, nw, set_idx, base, j, i, victim;
    logic [ADDR_W-1:0] key;
    logic [2:0] oldest;
    sb = eff_sb();
    bb = reg_bb;
    nw = eff_ways();
    set_idx = 32'((addr >> bb) & ((64'd1 << sb) - 64'd1));
    key = (sb + bb < 64) ? addr >> (sb + bb) : '0;
    base = set_idx * WAY_CAP;
    for (j = 0; j < nw; j++) begin
      if (line_ok[base+j] && line_key[base+j] == key) begin
        make_newest(base, nw, j, line_rank[base+j]);
        return LOOK_HIT;
      end
    end
    // A fill into an empty way ages every other valid way.
    for (j = 0; j < nw; j++) begin
      if (!line_ok[base+j]) begin
        for (i = 0; i < nw; i++) begin
          if (line_ok[base+i] && line_rank[base+i] < RANK_CAP)
            line_rank[base+i] = line_rank[base+i] + 3'd1;
        end
        line_ok[base+j]   = 1'b1;
        line_key[base+j]  = key;
        line_rank[base+j] = 3'd0;
        return LOOK_FILL;
      end
    end
    // Set is full: replace the oldest way, the lowest one on a tie.
    victim = 0;
    oldest = line_rank[base];
    for (j = 1; j < nw; j++) begin
      if (line_rank[base+j] > oldest) begin
        oldest = line_rank[base+j];
        victim = j;
      end
    end
    line_key[base+victim] = key;
    make_newest(base, nw, victim, oldest);
    return LOOK_EVICT;
  endfunction

  // Outcome of one access, including the second lookup of a modify.
  function automatic access_result_t next_result(logic [1:0] mode, logic [ADDR_W-1:0] addr);
    access_result_t r;
    lookup_t first;
    r = '0;
    if (mode != MODE_IGNORE) begin
      first = touch_line(addr);
      if (first == LOOK_HIT) begin
        r.hit  = 1'b1;
        n_hits = saturating_add1(n_hits);
      end else begin
        r.miss   = 1'b1;
        n_misses = saturating_add1(n_misses);
        if (first == LOOK_EVICT) begin
          r.eviction = 1'b1;
          n_evicts   = saturating_add1(n_evicts);
        end
      end
      if (mode == MODE_MODIFY && touch_line(addr) == LOOK_HIT) begin
        r.second_hit = 1'b1;
        n_hits       = saturating_add1(n_hits);
      end
    end
    r.total_hits      = n_hits;
    r.total_misses    = n_misses;
    r.total_evictions = n_evicts;
    return r;
  endfunction

  function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                      logic [CNT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Directed table builders.
  function automatic void tab_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    stim_row_t r;
    r = '0;
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    stim_rows.push_back(r);
  endfunction

  function automatic void tab_access(logic [1:0] mode, logic [ADDR_W-1:0] addr);
    stim_row_t r;
    r = '0;
    r.mode = mode;
    r.addr = addr;
    stim_rows.push_back(r);
  endfunction

  function automatic void tab_known(logic [1:0] mode, logic [ADDR_W-1:0] addr,
                                    logic h, logic m, logic e, logic s,
                                    int th, int tm, int te);
    stim_row_t r;
    r = '0;
    r.mode  = mode;
    r.addr  = addr;
    r.known = 1'b1;
    r.want  = '{total_evictions: te, total_misses: tm, total_hits: th,
                second_hit: s, eviction: e, miss: m, hit: h};
    stim_rows.push_back(r);
  endfunction

  // Offer one access and wait for its transfer, then record its outcome.
  task automatic send_access(logic [1:0] mode, logic [ADDR_W-1:0] addr, logic known,
                             access_result_t want);
    access_result_t calc;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    s_axis_tuser  <= mode;
    do @(posedge clk); while (!s_axis_tready);
    calc = next_result(mode, addr);
    outcome_q.push_back(known ? want : calc);
  endtask

  task automatic pause_sender();
    if (!no_pause && $urandom_range(0, 99) < send_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Wait until every outcome has arrived and the block has gone quiet.
  task automatic settle();
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_SET_BITS:   reg_sb   = val[2:0];
      REG_BLOCK_BITS: reg_bb   = val;
      REG_WAYS:       reg_ways = val[3:0];
      default: ;
    endcase
  endtask

  // Result side: random stall bursts, none in the closing stretch.
  always @(posedge clk) begin
    if (no_pause) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left    <= $urandom_range(1, 13) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest predicted outcome.
  always @(posedge clk) begin
    access_result_t want, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = access_result_t'(m_axis_tdata[99:0]);
      if (outcome_q.size() == 0) begin
        $error("result transfer with no access pending, tdata=%h", m_axis_tdata);
        mismatches++;
      end else begin
        want = outcome_q.pop_front();
        check_field("hit", want.hit, got.hit);
        check_field("miss", want.miss, got.miss);
        check_field("eviction", want.eviction, got.eviction);
        check_field("second_hit", want.second_hit, got.second_hit);
        check_field("total_hits", want.total_hits, got.total_hits);
        check_field("total_misses", want.total_misses, got.total_misses);
        check_field("total_evictions", want.total_evictions, got.total_evictions);
        results_seen++;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_run <= 0;
    end else if (idle_run == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    int i, ph, k, pick;
    int unsigned sb, nw;
    stim_row_t row;
    logic [1:0] mode;
    logic [ADDR_W-1:0] addr, off;

    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_SET_BITS;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_LOAD;
    for (i = 0; i < LINE_TOTAL; i++) begin
      line_ok[i]   = 1'b0;
      line_key[i]  = '0;
      line_rank[i] = '0;
    end
    n_hits   = '0;
    n_misses = '0;
    n_evicts = '0;
    reg_sb   = 3'd0;
    reg_bb   = 6'd0;
    reg_ways = 4'd1;

    // Reset geometry: one set, one way, the whole address is the tag.
    tab_known(MODE_LOAD,   64'h0, 1'b0, 1'b1, 1'b0, 1'b0, 0, 1, 0);
    tab_known(MODE_LOAD,   64'h0, 1'b1, 1'b0, 1'b0, 1'b0, 1, 1, 0);
    tab_known(MODE_STORE,  64'h1, 1'b0, 1'b1, 1'b1, 1'b0, 1, 2, 1);
    tab_known(MODE_MODIFY, 64'h1, 1'b1, 1'b0, 1'b0, 1'b1, 3, 2, 1);
    tab_known(MODE_IGNORE, '1,    1'b0, 1'b0, 1'b0, 1'b0, 3, 2, 1);
    tab_known(MODE_MODIFY, '1,    1'b0, 1'b1, 1'b1, 1'b1, 4, 3, 2);
    tab_known(MODE_LOAD,   '1,    1'b1, 1'b0, 1'b0, 1'b0, 5, 3, 2);
    // Oversized set bits and ways, offset so wide that the tag is always zero.
    tab_reg(REG_SET_BITS, 6'd7);
    tab_reg(REG_BLOCK_BITS, 6'd63);
    tab_reg(REG_WAYS, 6'd15);
    tab_access(MODE_LOAD,   64'h0);
    tab_access(MODE_LOAD,   64'h8000_0000_0000_0000);
    tab_access(MODE_STORE,  64'h7FFF_FFFF_FFFF_FFFF);
    tab_access(MODE_MODIFY, '1);
    // Zero ways acts as one; stale lines in higher ways are left alone.
    tab_reg(REG_WAYS, 6'd0);
    tab_reg(REG_SET_BITS, 6'd0);
    tab_reg(REG_BLOCK_BITS, 6'd0);
    tab_access(MODE_LOAD,   '1);
    tab_access(MODE_IGNORE, 64'h0);
    // Four ways in set 1: fill, evict the oldest, refresh, evict again.
    tab_reg(REG_SET_BITS, 6'd2);
    tab_reg(REG_BLOCK_BITS, 6'd4);
    tab_reg(REG_WAYS, 6'd4);
    tab_access(MODE_LOAD,   64'h010);
    tab_access(MODE_STORE,  64'h050);
    tab_access(MODE_LOAD,   64'h090);
    tab_access(MODE_LOAD,   64'h0D0);
    tab_access(MODE_LOAD,   64'h110);
    tab_access(MODE_LOAD,   64'h050);
    tab_access(MODE_STORE,  64'h150);
    tab_access(MODE_MODIFY, 64'h09F);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    for (i = 0; i < stim_rows.size(); i++) begin
      row = stim_rows[i];
      if (row.is_reg) begin
        if (i == 0 || !stim_rows[i-1].is_reg) begin
          s_axis_tvalid <= 1'b0;
          settle();
        end
        write_reg(row.reg_idx, row.reg_val);
        if (i + 1 == stim_rows.size() || !stim_rows[i+1].is_reg) begin
          cfg_we <= 1'b0;
          settings++;
        end
      end else begin
        send_access(row.mode, row.addr, row.known, row.want);
        pause_sender();
      end
    end

    // Random phases, each with its own geometry and idling mix.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      s_axis_tvalid <= 1'b0;
      settle();
      if (ph == 0) begin
        write_reg(REG_SET_BITS, 6'd7);
        write_reg(REG_BLOCK_BITS, 6'd0);
        write_reg(REG_WAYS, 6'd8);
      end else if (ph == 1) begin
        write_reg(REG_SET_BITS, 6'd0);
        write_reg(REG_BLOCK_BITS, 6'd63);
        write_reg(REG_WAYS, 6'd1);
      end else begin
        write_reg(REG_SET_BITS, 6'($urandom_range(0, 7)));
        write_reg(REG_BLOCK_BITS, ($urandom_range(0, 4) == 0) ?
                  6'($urandom_range(0, 63)) : 6'($urandom_range(0, 8)));
        write_reg(REG_WAYS, 6'($urandom_range(0, 15)));
      end
      cfg_we <= 1'b0;
      settings++;
      send_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
      if (ph == RAND_PHASES - 1) no_pause = 1'b1;

      // A small working set of tags, slightly larger than the ways in use.
      for (k = 0; k < 16; k++) key_pool[k] = {$urandom, $urandom};
      key_pool[0] = '0;
      key_pool[1] = '1;
      sb = eff_sb();
      nw = eff_ways();

      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        pick = $urandom_range(0, 9);
        mode = (pick < 3) ? MODE_LOAD : (pick < 6) ? MODE_STORE :
               (pick < 9) ? MODE_MODIFY : MODE_IGNORE;
        if ($urandom_range(0, 99) < 15) begin
          addr = {$urandom, $urandom};
        end else begin
          off  = {$urandom, $urandom} & ((64'd1 << reg_bb) - 64'd1);
          addr = off |
                 ((64'($urandom_range(0, 3)) & ((64'd1 << sb) - 64'd1)) << reg_bb) |
                 (key_pool[$urandom_range(0, nw + 2)] << (sb + reg_bb));
        end
        send_access(mode, addr, 1'b0, '0);
        pause_sender();
      end
    end

    s_axis_tvalid <= 1'b0;
    settle();
    $display("Checked %0d access results under %0d register settings.",
             results_seen, settings);
    $display("Totals reached: %0d hits, %0d misses, %0d evictions.",
             n_hits, n_misses, n_evicts);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: set_assoc_cache_lru_sim_top.f
design/sacl_pkg.sv
design/set_assoc_cache_lru_sim_top.sv
design/sacl_checker.sv
verif/tb_set_assoc_cache_lru_sim_top.sv
